// File: rtl/core/single_wire_sensor_frame_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// single wire sensor frame decoder assertion macros
// shared assertion wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define SWSFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swsfd_pkg.sv
// ----------------------------------------------------------------------------
// swsfd_pkg
// types, constants and helpers of the single wire sensor frame decoder
// ----------------------------------------------------------------------------
package swsfd_pkg;

  localparam int unsigned CaptureWidth  = 16;
  localparam int unsigned ErrorWidth    = 16;
  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned FrameBits     = 40;
  localparam int unsigned BitCountWidth = 6;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] CfgStartMin = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgStartMax = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgLowMin   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgLowMax   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgOneMin   = 3'd4;

  // register reset values, timer ticks
  localparam logic [CfgWidth-1:0] StartMinRst = 16'd70;
  localparam logic [CfgWidth-1:0] StartMaxRst = 16'd95;
  localparam logic [CfgWidth-1:0] LowMinRst   = 16'd40;
  localparam logic [CfgWidth-1:0] LowMaxRst   = 16'd65;
  localparam logic [CfgWidth-1:0] OneMinRst   = 16'd50;

  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhLow    = 2'd1,
    PhHigh   = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    StValid    = 2'd0,
    StNoStart  = 2'd1,
    StChecksum = 2'd2,
    StTrunc    = 2'd3
  } status_e;

  typedef struct packed {
    logic [CfgWidth-1:0] start_min;
    logic [CfgWidth-1:0] start_max;
    logic [CfgWidth-1:0] low_min;
    logic [CfgWidth-1:0] low_max;
    logic [CfgWidth-1:0] one_min;
  } cfg_t;

  typedef struct packed {
    logic [CaptureWidth-1:0] capture_time;
    logic                    frame_first;
    logic                    frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            humidity_high;
    logic [7:0]            humidity_low;
    logic [7:0]            temperature_high;
    logic [7:0]            temperature_low;
    logic [7:0]            received_sum;
    status_e               frame_status;
    logic [ErrorWidth-1:0] error_total;
  } out_item_t;

  // interval classification against the timing windows
  typedef struct packed {
    logic start_hit;
    logic low_hit;
    logic one_hit;
  } ivl_flags_t;

  // checksum of the four data bytes, modulo 256
  function automatic logic [7:0] byte_sum(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3);
    byte_sum = b0 + b1 + b2 + b3;
  endfunction

endpackage

// File: rtl/core/swsfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// swsfd_cfg_regs
// timing window registers, written through the configuration channel
// ----------------------------------------------------------------------------
module swsfd_cfg_regs
  import swsfd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStartMin: cfg_d.start_min = cfg_data_i;
        CfgStartMax: cfg_d.start_max = cfg_data_i;
        CfgLowMin:   cfg_d.low_min   = cfg_data_i;
        CfgLowMax:   cfg_d.low_max   = cfg_data_i;
        CfgOneMin:   cfg_d.one_min   = cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_min <= StartMinRst;
      cfg_q.start_max <= StartMaxRst;
      cfg_q.low_min   <= LowMinRst;
      cfg_q.low_max   <= LowMaxRst;
      cfg_q.one_min   <= OneMinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/swsfd_classify.sv
// ----------------------------------------------------------------------------
// swsfd_classify
// turns a capture into an interval and checks it against the windows
// ----------------------------------------------------------------------------
module swsfd_classify
  import swsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  output ivl_flags_t flags_o
);

  logic [CaptureWidth-1:0] prev_time_q;
  logic [CaptureWidth-1:0] interval;

  // wraps modulo the timer width
  assign interval = item_i.frame_first ? item_i.capture_time
                                       : item_i.capture_time - prev_time_q;

  assign flags_o.start_hit = (interval > cfg_i.start_min) && (interval < cfg_i.start_max);
  assign flags_o.low_hit   = (interval >= cfg_i.low_min) && (interval <= cfg_i.low_max);
  assign flags_o.one_hit   = (interval >= cfg_i.one_min);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
    end else if (advance_i) begin
      prev_time_q <= item_i.capture_time;
    end
  end

endmodule

// File: rtl/core/swsfd_decode.sv
// ----------------------------------------------------------------------------
// swsfd_decode
// frame state machine, bit shifter, checksum and result register
// ----------------------------------------------------------------------------
module swsfd_decode
  import swsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  in_item_t   item_i,
  input  ivl_flags_t flags_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  phase_e                  phase_q, phase_d, phase_c;
  logic                    start_seen_q, start_seen_d, start_seen_c;
  logic                    low_valid_q, low_valid_d, low_valid_c;
  logic [BitCountWidth-1:0] bit_count_q, bit_count_d, bit_count_c;
  logic [FrameBits-1:0]    data_q, data_d, data_c;
  logic [ErrorWidth-1:0]   fail_q, fail_d;
  logic                    fail_inc;
  logic                    emit;
  logic                    with_bytes;
  status_e                 status;
  logic                    out_valid_q;
  out_item_t               out_q, out_d;

  // a new frame restarts the decode state before this capture is used
  always_comb begin
    if (item_i.frame_first) begin
      phase_c      = PhSearch;
      start_seen_c = 1'b0;
      low_valid_c  = 1'b0;
      bit_count_c  = '0;
      data_c       = '0;
    end else begin
      phase_c      = phase_q;
      start_seen_c = start_seen_q;
      low_valid_c  = low_valid_q;
      bit_count_c  = bit_count_q;
      data_c       = data_q;
    end
  end

  // next state
  always_comb begin
    phase_d      = phase_c;
    start_seen_d = start_seen_c;
    low_valid_d  = low_valid_c;
    bit_count_d  = bit_count_c;
    data_d       = data_c;
    fail_inc     = 1'b0;
    emit         = 1'b0;
    with_bytes   = 1'b0;
    status       = StValid;

    unique case (phase_c)
      PhSearch: begin
        if (flags_i.start_hit) begin
          if (start_seen_c) begin
            phase_d      = PhLow;
            start_seen_d = 1'b0;
          end else begin
            start_seen_d = 1'b1;
          end
        end else begin
          start_seen_d = 1'b0;
        end
      end
      PhLow: begin
        low_valid_d = flags_i.low_hit;
        phase_d     = PhHigh;
      end
      PhHigh: begin
        phase_d     = PhLow;
        low_valid_d = 1'b0;
        if (low_valid_c) begin
          data_d      = {data_c[FrameBits-2:0], flags_i.one_hit};
          bit_count_d = bit_count_c + 1'b1;
          if (bit_count_c == BitCountWidth'(FrameBits - 1)) begin
            emit       = 1'b1;
            with_bytes = 1'b1;
            phase_d    = PhDone;
            if (byte_sum(data_d[39:32], data_d[31:24], data_d[23:16], data_d[15:8])
                == data_d[7:0]) begin
              status = StValid;
            end else begin
              status   = StChecksum;
              fail_inc = 1'b1;
            end
          end
        end
      end
      PhDone: ;  // captures ignored until the next frame start
      default: ;
    endcase

    // frame end before a complete word
    if (item_i.frame_last && (phase_c != PhDone) && !emit) begin
      emit         = 1'b1;
      start_seen_d = 1'b0;
      low_valid_d  = 1'b0;
      if (phase_d == PhSearch) begin
        status = StNoStart;
      end else begin
        status   = StTrunc;
        fail_inc = 1'b1;
      end
      phase_d = PhDone;
    end

    fail_d = (fail_inc && (fail_q != '1)) ? fail_q + 1'b1 : fail_q;
  end

  // result fields
  always_comb begin
    out_d.humidity_high    = with_bytes ? data_d[39:32] : 8'h00;
    out_d.humidity_low     = with_bytes ? data_d[31:24] : 8'h00;
    out_d.temperature_high = with_bytes ? data_d[23:16] : 8'h00;
    out_d.temperature_low  = with_bytes ? data_d[15:8]  : 8'h00;
    out_d.received_sum     = with_bytes ? data_d[7:0]   : 8'h00;
    out_d.frame_status     = status;
    out_d.error_total      = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSearch;
      start_seen_q <= 1'b0;
      low_valid_q  <= 1'b0;
      bit_count_q  <= '0;
      data_q       <= '0;
      fail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q      <= phase_d;
      start_seen_q <= start_seen_d;
      low_valid_q  <= low_valid_d;
      bit_count_q  <= bit_count_d;
      data_q       <= data_d;
      fail_q       <= fail_d;
      out_valid_q  <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/single_wire_sensor_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_decoder_core
// decodes the edge captures of a 40 bit pulse width sensor frame
// ----------------------------------------------------------------------------
// result path: the capture ending the frame passes the input register, then the
//   result register
// throughput: one capture per cycle unless a result waits unread, set by the single pass decode between them
// reset: asynchronous, clears frame state and error count, loads window defaults
`include "single_wire_sensor_frame_decoder_core_defines.svh"

module single_wire_sensor_frame_decoder_core
  import swsfd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i
);

  logic       s1_valid_q;
  in_item_t   s1_data_q;
  logic       advance;
  cfg_t       cfg;
  ivl_flags_t flags;
  logic [7:0] out_sum;

  // the held capture moves on whenever the result register can take it
  assign advance     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  swsfd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swsfd_classify u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_data_q),
    .cfg_i     (cfg),
    .flags_o   (flags)
  );

  swsfd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_data_q),
    .flags_i     (flags),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign out_sum = byte_sum(out_data_o.humidity_high, out_data_o.humidity_low,
                            out_data_o.temperature_high, out_data_o.temperature_low);

  `SWSFD_ASSERT_IMPL(a_valid_sum_matches, out_valid_o && (out_data_o.frame_status == StValid), out_sum == out_data_o.received_sum, "valid frame with bad checksum")

  `SWSFD_ASSERT_IMPL(a_no_bytes_on_abort, out_valid_o && ((out_data_o.frame_status == StNoStart) || (out_data_o.frame_status == StTrunc)), (out_data_o.humidity_high == 8'h00) && (out_data_o.humidity_low == 8'h00) && (out_data_o.temperature_high == 8'h00) && (out_data_o.temperature_low == 8'h00) && (out_data_o.received_sum == 8'h00), "aborted frame carries data bytes")

  `SWSFD_ASSERT_IMPL(a_stall_only_when_full, !in_ready_o, s1_valid_q && out_valid_o && !out_ready_i, "input stalled without a blocked result")

  `SWSFD_ASSERT_NEXT(a_taken_result_clears, out_valid_o && out_ready_i && !advance, !out_valid_o, "result delivered twice")

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single wire sensor frame decoder core. Edge
// capture beats are generated from interval patterns: start pairs, bit pairs
// carrying a byte word with a good or broken checksum, truncated, noisy and
// abandoned frames. A capture-level decoder model predicts every result beat,
// and each result is compared field by field as it leaves the core. The timing
// windows are reprogrammed between phases, with their extremes among them.
// ----------------------------------------------------------------------------
module tb_top
  import swsfd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CaptureWidth-1:0] last_capture;
    phase_e                  phase;
    logic                    start_armed;
    logic                    low_ok;
    int unsigned             nbits;
    logic [FrameBits-1:0]    bits;
    logic [ErrorWidth-1:0]   failures;
  } decoder_state_t;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_item_t                 in_beat   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_beat;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]      cfg_value = '0;

  in_item_t                pending_captures[$];
  out_item_t               frames_expected[$];
  decoder_state_t          dec;
  cfg_t                    win;
  logic [CaptureWidth-1:0] gen_prev = '0;
  int unsigned             n_queued = 0;
  int unsigned             n_accepted = 0;
  int unsigned             mismatches = 0;
  int unsigned             in_gap = 0;
  int unsigned             in_calm = 0;
  int unsigned             out_stall = 0;
  int unsigned             out_calm = 0;
  out_item_t               want;

  single_wire_sensor_frame_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_value)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int unsigned idle_len(inout int unsigned calm_left);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 2) begin
      calm_left = $urandom_range(20, 200);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // decoder model: one capture beat in, zero or one frame result out
  function automatic void decode_capture(input in_item_t cap);
    logic [CaptureWidth-1:0] ivl;
    logic [7:0]              sum;
    out_item_t               res;
    logic                    emit;
    logic                    was_done;
    emit = 1'b0;
    res  = '0;
    if (cap.frame_first) begin
      ivl             = cap.capture_time;
      dec.phase       = PhSearch;
      dec.start_armed = 1'b0;
      dec.low_ok      = 1'b0;
      dec.nbits       = 0;
      dec.bits        = '0;
    end else begin
      ivl = cap.capture_time - dec.last_capture;
    end
    dec.last_capture = cap.capture_time;
    was_done = (dec.phase == PhDone);
    case (dec.phase)
      PhSearch: begin
        if (ivl > win.start_min && ivl < win.start_max) begin
          if (dec.start_armed) begin
            dec.phase       = PhLow;
            dec.start_armed = 1'b0;
          end else begin
            dec.start_armed = 1'b1;
          end
        end else begin
          dec.start_armed = 1'b0;
        end
      end
      PhLow: begin
        dec.low_ok = (ivl >= win.low_min && ivl <= win.low_max);
        dec.phase  = PhHigh;
      end
      PhHigh: begin
        dec.phase = PhLow;
        if (dec.low_ok) begin
          dec.bits = {dec.bits[FrameBits-2:0], ivl >= win.one_min};
          dec.nbits++;
          if (dec.nbits >= FrameBits) begin
            sum = dec.bits[39:32] + dec.bits[31:24] + dec.bits[23:16] + dec.bits[15:8];
            res.humidity_high    = dec.bits[39:32];
            res.humidity_low     = dec.bits[31:24];
            res.temperature_high = dec.bits[23:16];
            res.temperature_low  = dec.bits[15:8];
            res.received_sum     = dec.bits[7:0];
            res.frame_status     = (sum == dec.bits[7:0]) ? StValid : StChecksum;
            if (res.frame_status != StValid && dec.failures != '1) dec.failures++;
            dec.phase = PhDone;
            emit      = 1'b1;
          end
        end
        dec.low_ok = 1'b0;
      end
      default: ;
    endcase
    // frame end with no checksum result on this beat
    if (!emit && !was_done && cap.frame_last) begin
      if (dec.phase == PhSearch) begin
        res.frame_status = StNoStart;
      end else begin
        res.frame_status = StTrunc;
        if (dec.failures != '1) dec.failures++;
      end
      dec.phase       = PhDone;
      dec.start_armed = 1'b0;
      dec.low_ok      = 1'b0;
      emit            = 1'b1;
    end
    if (emit) begin
      res.error_total = dec.failures;
      frames_expected.push_back(res);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
    end
  endfunction

  // capture driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_capture(in_beat);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_captures.size() != 0) begin
          in_beat  <= pending_captures.pop_front();
          in_valid <= 1'b1;
          in_gap = idle_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_expected.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result beat, expected none, actual %p", $time, out_beat);
        end else begin
          want = frames_expected.pop_front();
          check_field("humidity_high", want.humidity_high, out_beat.humidity_high);
          check_field("humidity_low", want.humidity_low, out_beat.humidity_low);
          check_field("temperature_high", want.temperature_high, out_beat.temperature_high);
          check_field("temperature_low", want.temperature_low, out_beat.temperature_low);
          check_field("received_sum", want.received_sum, out_beat.received_sum);
          check_field("frame_status", want.frame_status, out_beat.frame_status);
          check_field("error_total", want.error_total, out_beat.error_total);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = idle_len(out_calm);
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgStartMin: win.start_min = val;
      CfgStartMax: win.start_max = val;
      CfgLowMin:   win.low_min   = val;
      CfgLowMax:   win.low_max   = val;
      CfgOneMin:   win.one_min   = val;
      default: ;
    endcase
  endtask

  task automatic load_windows(input cfg_t w);
    write_reg(CfgStartMin, w.start_min);
    write_reg(CfgStartMax, w.start_max);
    write_reg(CfgLowMin, w.low_min);
    write_reg(CfgLowMax, w.low_max);
    write_reg(CfgOneMin, w.one_min);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || frames_expected.size() != 0) @(posedge clk_i);
    // a capture that gives no result may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_ivl(input int unsigned ivl, input bit first, input bit last);
    in_item_t cap;
    cap.capture_time = first ? CaptureWidth'(ivl) : gen_prev + CaptureWidth'(ivl);
    cap.frame_first  = first;
    cap.frame_last   = last;
    gen_prev = cap.capture_time;
    pending_captures.push_back(cap);
    n_queued++;
  endtask

  function automatic int unsigned start_ivl();
    int unsigned lo, hi;
    lo = win.start_min;
    hi = win.start_max;
    if (hi > lo + 1) begin
      case ($urandom_range(0, 3))
        0:       return lo + 1;
        1:       return hi - 1;
        default: return $urandom_range(lo + 1, hi - 1);
      endcase
    end
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned non_start_ivl();
    case ($urandom_range(0, 2))
      0:       return win.start_min;
      1:       return win.start_max;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int unsigned low_ivl();
    int unsigned lo, hi;
    lo = win.low_min;
    hi = win.low_max;
    if (lo > hi) return $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int unsigned bad_low_ivl();
    int unsigned lo, hi;
    lo = win.low_min;
    hi = win.low_max;
    if (lo > 0) return $urandom_range(0, lo - 1);
    if (hi < 65535) return $urandom_range(hi + 1, 65535);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned high_ivl(input bit one);
    int unsigned m;
    m = win.one_min;
    if (one) begin
      if (m == 65535 || $urandom_range(0, 3) == 0) return m;
      return $urandom_range(m, (m + 80 > 65535) ? 65535 : m + 80);
    end
    if (m == 0) return $urandom_range(0, 65535);
    if ($urandom_range(0, 3) == 0) return m - 1;
    return $urandom_range((m > 80) ? m - 80 : 0, m - 1);
  endfunction

  // one frame: noise, or a start pair and 40 bit pairs, then cut, padded or left open
  task automatic gen_frame();
    int unsigned          ivls[$];
    int unsigned          kind, mode, keep;
    logic [FrameBits-1:0] word;
    logic [7:0]           sum;
    kind = $urandom_range(0, 99);
    mode = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) begin
        ivls.push_back($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 200));
      end
    end else begin
      repeat ($urandom_range(0, 2)) ivls.push_back(non_start_ivl());
      if ($urandom_range(0, 3) == 0) begin
        ivls.push_back(start_ivl());
        ivls.push_back(non_start_ivl());
      end
      ivls.push_back(start_ivl());
      ivls.push_back(start_ivl());
      word[39:8] = $urandom;
      sum = word[39:32] + word[31:24] + word[23:16] + word[15:8];
      word[7:0] = ($urandom_range(0, 4) == 0) ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
      for (int i = FrameBits - 1; i >= 0; i--) begin
        // a pair with its low phase out of window carries no bit
        if ($urandom_range(0, 19) == 0) begin
          ivls.push_back(bad_low_ivl());
          ivls.push_back(high_ivl($urandom_range(0, 1)));
        end
        ivls.push_back(low_ivl());
        ivls.push_back(high_ivl(word[i]));
      end
      if ($urandom_range(0, 3) == 0) begin
        keep = $urandom_range(1, ivls.size() - 1);
        while (ivls.size() > keep) void'(ivls.pop_back());
      end
    end
    if (mode >= 60 && mode < 80) begin
      repeat ($urandom_range(1, 3)) ivls.push_back($urandom_range(0, 65535));
    end
    foreach (ivls[k]) push_ivl(ivls[k], k == 0, mode < 80 && k == ivls.size() - 1);
  endtask

  initial begin
    cfg_t        w;
    int unsigned target;
    dec = '{last_capture: '0, phase: PhSearch, start_armed: 1'b0, low_ok: 1'b0,
            nbits: 0, bits: '0, failures: '0};
    win = '{start_min: StartMinRst, start_max: StartMaxRst, low_min: LowMinRst,
            low_max: LowMaxRst, one_min: OneMinRst};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // captures before any frame start, bit then end after the low phase
    push_ivl(100, 0, 0);
    push_ivl(80, 0, 0);
    push_ivl(80, 0, 0);
    push_ivl(50, 0, 0);
    push_ivl(50, 0, 1);
    // single capture frame at full scale, then an ignored capture that wraps
    push_ivl(65535, 1, 1);
    push_ivl(71, 0, 1);
    // start found on the last capture
    push_ivl(80, 1, 0);
    push_ivl(80, 0, 1);
    // frame abandoned by a new start, the new one ends after a low phase
    push_ivl(0, 1, 0);
    push_ivl(85, 0, 0);
    push_ivl(85, 0, 0);
    push_ivl(50, 0, 0);
    push_ivl(75, 1, 0);
    push_ivl(75, 0, 0);
    push_ivl(40, 0, 1);
    // no start, ending at the top capture value
    push_ivl(71, 1, 0);
    push_ivl(65464, 0, 1);
    // window edges: start bounds, a dropped pair, a zero bit then the end
    push_ivl(70, 1, 0);
    push_ivl(95, 0, 0);
    push_ivl(71, 0, 0);
    push_ivl(94, 0, 0);
    push_ivl(39, 0, 0);
    push_ivl(31, 0, 0);
    push_ivl(65, 0, 0);
    push_ivl(49, 0, 1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: w = '{start_min: 16'd0, start_max: 16'hffff, low_min: 16'd0,
                   low_max: 16'hffff, one_min: 16'hffff};
          2: w = '{start_min: 16'hfffd, start_max: 16'hffff, low_min: 16'hffff,
                   low_max: 16'hffff, one_min: 16'd0};
          3: w = '{start_min: 16'hffff, start_max: 16'd0, low_min: 16'hffff,
                   low_max: 16'd0, one_min: 16'd1};
          4: begin
            w.start_min = $urandom_range(0, 2000);
            w.start_max = w.start_min + $urandom_range(2, 400);
            w.low_min   = $urandom_range(0, 3000);
            w.low_max   = w.low_min + $urandom_range(0, 500);
            w.one_min   = $urandom_range(0, 4000);
          end
          default: w = '{start_min: StartMinRst, start_max: StartMaxRst, low_min: LowMinRst,
                         low_max: LowMaxRst, one_min: OneMinRst};
        endcase
        load_windows(w);
      end
      target = n_queued + 1150 / 6;
      while (n_queued < target) gen_frame();
    end

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t ns: timeout, %0d beats still expected", $time, frames_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/swsfd_pkg.sv
rtl/core/swsfd_cfg_regs.sv
rtl/core/swsfd_classify.sv
rtl/core/swsfd_decode.sv
rtl/core/single_wire_sensor_frame_decoder_core.sv
bench/tb_top.sv
